FILE: rtl/core/yuv420_to_rgb32_converter_top_macros.svh
// ----------------------------------------------------------------------------
// yuv420_to_rgb32_converter_top_macros
// Assertion helpers for the YUV420 to RGB32 converter; clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef YUV420_TO_RGB32_CONVERTER_TOP_MACROS_SVH
`define YUV420_TO_RGB32_CONVERTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define YRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define YRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/yrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_pkg
// Shared types and constants of the YUV420 to RGB32 converter.
// ----------------------------------------------------------------------------
package yrc_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_ROWS      = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(320);
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(240);

  localparam int ROW_W = 10;

  // BT.601 integer coefficients
  localparam int COEF_Y  = 298;
  localparam int COEF_RV = 409;
  localparam int COEF_GU = -100;
  localparam int COEF_GV = -208;
  localparam int COEF_BU = 516;
  localparam int ROUND_Y = 128;
  localparam logic [7:0] LUMA_OFFSET   = 8'd16;
  localparam logic [7:0] CHROMA_OFFSET = 8'd128;
  localparam logic [7:0] ALPHA         = 8'hff;
  localparam int CHAN_MAX = 255;

  typedef struct packed {
    logic valid;
    logic odd;
    logic row_end;
    logic frame_end;
  } yrc_ctrl_t;

endpackage

FILE: rtl/core/yrc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_if
// Valid/ready channels of the converter: pixel input, pixel output, config.
// ----------------------------------------------------------------------------
interface yrc_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] luma_second;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (output valid, luma_first, luma_second, chroma_blue, chroma_red,
                  input ready);
  modport sink (input valid, luma_first, luma_second, chroma_blue, chroma_red,
                output ready);
endinterface

interface yrc_out_if ();
  logic        valid;
  logic        ready;
  logic [31:0] pixel_first;
  logic [31:0] pixel_second;
  logic        row_end;
  logic        frame_end;

  modport source (output valid, pixel_first, pixel_second, row_end, frame_end,
                  input ready);
  modport sink (input valid, pixel_first, pixel_second, row_end, frame_end,
                output ready);
endinterface

interface yrc_cfg_if import yrc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

FILE: rtl/core/yrc_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_line_store
// Chroma line store: one {U,V} entry per pair column, registered read.
// ----------------------------------------------------------------------------
module yrc_line_store import yrc_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH / 2,
  parameter int COL_W = 9
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [COL_W-1:0] addr,
  input  logic [15:0]      wdata,
  output logic [15:0]      rdata
);

  logic [15:0] mem [DEPTH];

  // Writes come from even rows and only odd rows use the read data; every
  // entry an odd row reads was written while the row above streamed.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

FILE: rtl/core/yrc_color_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_color_pipe
// Two-stage color math: weighted terms, then sum, clip and pixel packing.
// ----------------------------------------------------------------------------
module yrc_color_pipe import yrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  yrc_ctrl_t   ctrl_a,
  input  logic [7:0]  y0_a,
  input  logic [7:0]  y1_a,
  input  logic [7:0]  u_a,
  input  logic [7:0]  v_a,
  input  logic [15:0] store_rd,
  output yrc_ctrl_t   ctrl_c,
  output logic [31:0] pix0_c,
  output logic [31:0] pix1_c
);

  function automatic logic signed [9:0] luma_term(input logic [7:0] y);
    logic signed [8:0]  ym;
    logic signed [17:0] p;
    ym = $signed({1'b0, y}) - $signed({1'b0, LUMA_OFFSET});
    p  = 18'(ym) * 18'(COEF_Y) + 18'(ROUND_Y);
    return p[17:8];
  endfunction

  function automatic logic [7:0] clip8(input logic signed [11:0] s);
    logic [7:0] r;
    if (s < 0) begin
      r = 8'd0;
    end else if (s > 12'(CHAN_MAX)) begin
      r = 8'(CHAN_MAX);
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

  logic [7:0]         u_sel, v_sel;
  logic signed [7:0]  d, e;
  logic signed [16:0] p_rv;
  logic signed [15:0] p_gu, p_gv;
  logic signed [17:0] p_bu;

  yrc_ctrl_t          ctrl_b;
  logic signed [9:0]  yt0_b, yt1_b, tb_b;
  logic signed [8:0]  tr_b;
  logic signed [7:0]  tgu_b, tgv_b;

  logic signed [11:0] r0, g0, b0, r1, g1, b1;

  // odd rows reuse the chroma stored by the row above
  assign u_sel = ctrl_a.odd ? store_rd[15:8] : u_a;
  assign v_sel = ctrl_a.odd ? store_rd[7:0]  : v_a;
  // x - 128 wraps to the two's complement of the offset value
  assign d = $signed(8'(u_sel - CHROMA_OFFSET));
  assign e = $signed(8'(v_sel - CHROMA_OFFSET));

  assign p_rv = 17'(e) * 17'(COEF_RV);
  assign p_gu = 16'(d) * 16'(COEF_GU);
  assign p_gv = 16'(e) * 16'(COEF_GV);
  assign p_bu = 18'(d) * 18'(COEF_BU);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_b <= '0;
    end else if (en) begin
      ctrl_b <= ctrl_a;
    end
  end

  // dropping the low byte is the floor shift
  always_ff @(posedge clk) begin
    if (en) begin
      yt0_b <= luma_term(y0_a);
      yt1_b <= luma_term(y1_a);
      tr_b  <= p_rv[16:8];
      tgu_b <= p_gu[15:8];
      tgv_b <= p_gv[15:8];
      tb_b  <= p_bu[17:8];
    end
  end

  assign r0 = 12'(yt0_b) + 12'(tr_b);
  assign g0 = 12'(yt0_b) + 12'(tgu_b) + 12'(tgv_b);
  assign b0 = 12'(yt0_b) + 12'(tb_b);
  assign r1 = 12'(yt1_b) + 12'(tr_b);
  assign g1 = 12'(yt1_b) + 12'(tgu_b) + 12'(tgv_b);
  assign b1 = 12'(yt1_b) + 12'(tb_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_c <= '0;
    end else if (en) begin
      ctrl_c <= ctrl_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix0_c <= {ALPHA, clip8(r0), clip8(g0), clip8(b0)};
      pix1_c <= {ALPHA, clip8(r1), clip8(g1), clip8(b1)};
    end
  end

endmodule

FILE: rtl/core/yuv420_to_rgb32_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_to_rgb32_converter_top
// 4:2:0 luma-pair stream to 0xFFRRGGBB pixel pairs with a chroma line store.
// ----------------------------------------------------------------------------
//  port     | dir | transaction
//  cfg      | in  | register index + 11-bit value (0 frame_width, 1 height)
//  pix_in   | in  | two Y samples plus U, V of the pair
//  pix_out  | out | two ARGB pixels, row end and frame end flags
//
// One transaction per cycle while pix_out is not stalled; pix_out.valid follows
// the input through three registered stages (store read, term multiply, sum/clip output register).
// pix_in.ready is low only while the output register holds an untaken pair;
// a stall freezes all three stages together.
// Reset clears counters, stage valids and config (320 x 240); the line store
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "yuv420_to_rgb32_converter_top_macros.svh"

module yuv420_to_rgb32_converter_top import yrc_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  yrc_cfg_if.sink    cfg,
  yrc_in_if.sink     pix_in,
  yrc_out_if.source  pix_out
);

  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int COL_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW = ($clog2(STORE_DEPTH + 1) > 10) ? $clog2(STORE_DEPTH + 1) : 10;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [PW-1:0]    pairs_raw, pairs;
  logic [CFG_W-1:0] rows;
  logic             rend, fend;
  logic             en, in_fire;

  yrc_ctrl_t   ctrl_a, ctrl_c;
  logic [7:0]  y0_a, y1_a, u_a, v_a;
  logic [15:0] store_rd;
  logic [31:0] pix0_c, pix1_c;

  // config port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // pairs per row, saturated to 1..STORE_DEPTH; rows to 1..MAX_ROWS
  assign pairs_raw = PW'(frame_width[CFG_W-1:1]);

  always_comb begin
    if (pairs_raw == '0) begin
      pairs = PW'(1);
    end else if (pairs_raw > PW'(STORE_DEPTH)) begin
      pairs = PW'(STORE_DEPTH);
    end else begin
      pairs = pairs_raw;
    end
    if (frame_height == '0) begin
      rows = CFG_W'(1);
    end else if (frame_height > CFG_W'(MAX_ROWS)) begin
      rows = CFG_W'(MAX_ROWS);
    end else begin
      rows = frame_height;
    end
  end

  // ">=" also wraps counters left beyond a shrunk frame
  assign rend = (PW'(col) + PW'(1)) >= pairs;
  assign fend = rend && ((CFG_W'(row) + CFG_W'(1)) >= rows);

  // whole pipe advances unless the output register is stuck
  assign en            = !ctrl_c.valid || pix_out.ready;
  assign pix_in.ready  = en;
  assign in_fire       = pix_in.valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (rend) begin
        col <= '0;
        row <= fend ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a <= '0;
    end else if (en) begin
      ctrl_a <= '{valid: in_fire, odd: row[0], row_end: rend, frame_end: fend};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y0_a <= pix_in.luma_first;
      y1_a <= pix_in.luma_second;
      u_a  <= pix_in.chroma_blue;
      v_a  <= pix_in.chroma_red;
    end
  end

  yrc_line_store #(
    .DEPTH (STORE_DEPTH),
    .COL_W (COL_W)
  ) u_store (
    .clk   (clk),
    .en    (en),
    .we    (in_fire && !row[0]),
    .addr  (col),
    .wdata ({pix_in.chroma_blue, pix_in.chroma_red}),
    .rdata (store_rd)
  );

  yrc_color_pipe u_color (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctrl_a   (ctrl_a),
    .y0_a     (y0_a),
    .y1_a     (y1_a),
    .u_a      (u_a),
    .v_a      (v_a),
    .store_rd (store_rd),
    .ctrl_c   (ctrl_c),
    .pix0_c   (pix0_c),
    .pix1_c   (pix1_c)
  );

  assign pix_out.valid        = ctrl_c.valid;
  assign pix_out.pixel_first  = pix0_c;
  assign pix_out.pixel_second = pix1_c;
  assign pix_out.row_end      = ctrl_c.row_end;
  assign pix_out.frame_end    = ctrl_c.frame_end;

  `YRC_ASSERT_NOW(a_fend_rend, ctrl_c.valid && ctrl_c.frame_end, ctrl_c.row_end, "lone frame end")
  `YRC_ASSERT_NEXT(a_col_wraps, in_fire && rend, col == '0, "column did not wrap at row end")
  `YRC_ASSERT_NOW(a_col_in_store, 1'b1, PW'(col) < PW'(STORE_DEPTH), "column beyond store")
  `YRC_ASSERT_NEXT(a_stall_holds_a, !en, ctrl_a == $past(ctrl_a), "stage A moved during stall")

endmodule
